// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/aee_pkg.sv =====
// Types and constants of the exception entry unit.
package aee_pkg;

    typedef struct packed {
        logic        func;
        logic [2:0]  line_id;
        logic        line_level;
        logic        swi_request;
        logic [31:0] current_psr;
        logic [31:0] current_pc;
    } t_in_beat;

    typedef struct packed {
        logic        taken;
        logic [2:0]  exception_kind;
        logic [4:0]  new_mode;
        logic [31:0] link_value;
        logic [31:0] saved_psr;
        logic [31:0] new_psr;
        logic [31:0] vector_address;
    } t_out_beat;

    localparam int unsigned PADDR_W = 1;
    localparam logic [PADDR_W-1:0] ADDR_HIGH_VECTORS = '0;

    localparam logic FUNC_DRIVE = 1'b0;

    localparam logic [2:0] LINE_IRQ  = 3'd0;
    localparam logic [2:0] LINE_FIQ  = 3'd1;
    localparam logic [2:0] LINE_DABT = 3'd2;
    localparam logic [2:0] LINE_PABT = 3'd3;
    localparam logic [2:0] LINE_UND  = 3'd4;

    localparam logic [2:0] KIND_DABT = 3'd0;
    localparam logic [2:0] KIND_FIQ  = 3'd1;
    localparam logic [2:0] KIND_IRQ  = 3'd2;
    localparam logic [2:0] KIND_PABT = 3'd3;
    localparam logic [2:0] KIND_UND  = 3'd4;
    localparam logic [2:0] KIND_SWI  = 3'd5;

    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SVC = 5'h13;

    localparam logic [31:0] VEC_DABT = 32'h0000_0010;
    localparam logic [31:0] VEC_FIQ  = 32'h0000_001C;
    localparam logic [31:0] VEC_IRQ  = 32'h0000_0018;
    localparam logic [31:0] VEC_PABT = 32'h0000_000C;
    localparam logic [31:0] VEC_UND  = 32'h0000_0004;
    localparam logic [31:0] VEC_SWI  = 32'h0000_0008;
    localparam logic [31:0] HIGH_BASE = 32'hFFFF_0000;

    localparam int unsigned PSR_I_BIT = 7;
    localparam int unsigned PSR_F_BIT = 6;
    localparam int unsigned PSR_T_BIT = 5;

endpackage

// ===== sv/arm_exception_entry_unit_top.sv =====
// Exception entry unit: pending flags, priority selection and entry values.
// An input beat may drive one exception line (irq, fiq, data abort, prefetch
// abort, undefined) to a level and may request a software interrupt; the unit
// then enters the highest-priority pending, unmasked exception. Every input
// beat yields exactly one output beat carrying taken, kind, new mode, link
// value, saved and new PSR and the vector address; when nothing is taken all
// fields are zero.
// The result of a beat accepted at one edge is shown in the output register
// from the next cycle. Throughput is one beat per cycle while the receiver
// does not stall, set by the single output register of the selection result.
// When the receiver stalls, the held output beat stays unchanged and the
// input side is stalled in the same cycle only while that register is full.
// Reset clears the six pending flags, the output valid and high_vectors.
// The APB port holds one register, high_vectors, at byte address 0; it moves
// exception vectors to the 0xFFFF0000 base.
`include "assert_macros.svh"

module arm_exception_entry_unit_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  aee_pkg::t_in_beat                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output aee_pkg::t_out_beat                  o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aee_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import aee_pkg::*;

    logic      r_high_vectors;
    logic      r_irq, r_fiq, r_dabt, r_pabt, r_und, r_swi;
    logic      n_irq, n_fiq, n_dabt, n_pabt, n_und, n_swi;
    logic      r_out_valid;
    t_out_beat r_out_data;
    t_out_beat n_out_data;
    logic      in_accept;
    logic      cfg_write;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && (paddr == ADDR_HIGH_VECTORS);
    assign prdata      = (paddr == ADDR_HIGH_VECTORS) ? {31'd0, r_high_vectors} : 32'd0;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        logic        drv;
        logic        lvl;
        logic        thumb;
        logic [31:0] psr;
        logic [31:0] pc2;
        logic [31:0] pc4;
        logic [31:0] vec;
        logic        fiq_entry;

        drv   = (i_in_data.func == FUNC_DRIVE);
        lvl   = i_in_data.line_level;
        psr   = i_in_data.current_psr;
        thumb = psr[PSR_T_BIT];
        pc2   = i_in_data.current_pc + 32'd2;
        pc4   = i_in_data.current_pc + 32'd4;
        vec   = '0;
        fiq_entry = 1'b0;

        n_irq  = (drv && i_in_data.line_id == LINE_IRQ)  ? lvl : r_irq;
        n_fiq  = (drv && i_in_data.line_id == LINE_FIQ)  ? lvl : r_fiq;
        n_dabt = (drv && i_in_data.line_id == LINE_DABT) ? lvl : r_dabt;
        n_pabt = (drv && i_in_data.line_id == LINE_PABT) ? lvl : r_pabt;
        n_und  = (drv && i_in_data.line_id == LINE_UND)  ? lvl : r_und;
        n_swi  = r_swi || i_in_data.swi_request;

        n_out_data = '0;
        n_out_data.taken = 1'b1;
        if (n_dabt) begin
            n_out_data.exception_kind = KIND_DABT;
            n_out_data.new_mode       = MODE_ABT;
            n_out_data.link_value     = pc4;
            vec                       = VEC_DABT;
            n_dabt                    = 1'b0;
        end else if (n_fiq && !psr[PSR_F_BIT]) begin
            n_out_data.exception_kind = KIND_FIQ;
            n_out_data.new_mode       = MODE_FIQ;
            n_out_data.link_value     = pc4;
            vec                       = VEC_FIQ;
            fiq_entry                 = 1'b1;
        end else if (n_irq && !psr[PSR_I_BIT]) begin
            n_out_data.exception_kind = KIND_IRQ;
            n_out_data.new_mode       = MODE_IRQ;
            n_out_data.link_value     = pc4;
            vec                       = VEC_IRQ;
        end else if (n_pabt) begin
            n_out_data.exception_kind = KIND_PABT;
            n_out_data.new_mode       = MODE_ABT;
            n_out_data.link_value     = pc4;
            vec                       = VEC_PABT;
            n_pabt                    = 1'b0;
        end else if (n_und) begin
            n_out_data.exception_kind = KIND_UND;
            n_out_data.new_mode       = MODE_UND;
            n_out_data.link_value     = thumb ? pc2 : i_in_data.current_pc;
            vec                       = VEC_UND;
            n_und                     = 1'b0;
        end else if (n_swi) begin
            n_out_data.exception_kind = KIND_SWI;
            n_out_data.new_mode       = MODE_SVC;
            n_out_data.link_value     = thumb ? pc2 : pc4;
            vec                       = VEC_SWI;
            n_swi                     = 1'b0;
        end else begin
            n_out_data.taken = 1'b0;
        end

        if (n_out_data.taken) begin
            n_out_data.saved_psr      = psr;
            n_out_data.new_psr        = {psr[31:8], 1'b1, psr[PSR_F_BIT] | fiq_entry, 1'b0,
                                         n_out_data.new_mode};
            n_out_data.vector_address = r_high_vectors ? (vec | HIGH_BASE) : vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_vectors <= 1'b0;
            r_irq          <= 1'b0;
            r_fiq          <= 1'b0;
            r_dabt         <= 1'b0;
            r_pabt         <= 1'b0;
            r_und          <= 1'b0;
            r_swi          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_high_vectors <= pwdata[0];
            end
            if (in_accept) begin
                r_irq  <= n_irq;
                r_fiq  <= n_fiq;
                r_dabt <= n_dabt;
                r_pabt <= n_pabt;
                r_und  <= n_und;
                r_swi  <= n_swi;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    `ASSERT_IMPLY(a_idle_zero, i_clk, i_rst_n, r_out_valid && !r_out_data.taken, r_out_data.new_psr == 32'd0 && r_out_data.vector_address == 32'd0 && r_out_data.link_value == 32'd0)
    `ASSERT_NEXT(a_dabt_clears, i_clk, i_rst_n, in_accept && n_out_data.taken && n_out_data.exception_kind == KIND_DABT, !r_dabt)
    `ASSERT_IMPLY(a_fiq_masks, i_clk, i_rst_n, r_out_valid && r_out_data.taken && r_out_data.exception_kind == KIND_FIQ, r_out_data.new_psr[PSR_F_BIT] && r_out_data.new_psr[PSR_I_BIT])
    `ASSERT_IMPLY(a_stall_only_full, i_clk, i_rst_n, o_in_stall, r_out_valid)

endmodule
